// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the sorted list table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check an implication on every rising clock edge outside of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg
// Types, constants and helpers shared by the sorted list table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  // Table geometry
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int OUT_DATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PLACE,
    S_DEL_SCAN,
    S_DEL_SHIFT,
    S_DUMP,
    S_RESP
  } state_e;

  // Index register update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  // Entry count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // Read address source
  typedef enum logic [2:0] {
    RA_ZERO,
    RA_CNT_M1,
    RA_IDX_M2,
    RA_IDX_P1,
    RA_IDX_P2
  } rd_addr_e;

  // Write data source
  typedef enum logic {
    WS_RDATA,
    WS_VALUE
  } wr_src_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     load_in;
    idx_op_e  idx_op;
    logic     rd_en;
    rd_addr_e rd_addr;
    logic     wr_en;
    wr_src_e  wr_src;
    cnt_op_e  cnt_op;
    logic     out_load;
    status_e  out_status;
    logic     out_elem;
    logic     out_last;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic rd_lt;
    logic rd_eq;
    logic idx_is_one;
    logic idx_p1_last;
    logic idx_p2_end;
    logic out_free;
  } sts_t;

  // Fit an entry count into the result field
  function automatic logic [COUNT_W-1:0] to_count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, c};
    return w[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sorted_list_table.sv -----
// ----------------------------------------------------------------------------
// sorted_list_table
// Bounded table of signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY (16) signed values in ascending order in a
// single-port-read RAM; duplicates are kept. It takes one operation at a time.
// An insert shifts each entry not less than the value up one slot, from the
// top down, and writes the value into the gap; a delete scans from the bottom
// for an equal entry and pulls each later entry down over it; a dump returns
// one result per stored entry, in order, and waits while the output is stalled.
// Errors and unused operation codes give a single result. Each step of the
// search and shift needs one RAM access. A finished result sits in an output
// register, so the next operation is accepted while it waits. Entry contents
// are undefined after reset; only the entry count and index are cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table import slt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [DATA_W-1:0]     s_axis_tdata,   // [31:0] value
  input  wire logic [OP_W-1:0]       s_axis_tuser,   // [1:0] operation
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [31:0] element, [36:32] entry_count
  output logic [STATUS_W-1:0]        m_axis_tuser,   // [1:0] status
  output logic                       m_axis_tlast    // last result of the operation
);

  cmd_t               cmd;
  sts_t               sts;
  logic [DATA_W-1:0]  element;
  logic [COUNT_W-1:0] entry_count;

  slt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slt_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (m_axis_tuser),
    .out_element_o (element),
    .out_count_o   (entry_count),
    .out_last_o    (m_axis_tlast)
  );

  // Pack the result payload, zero fill to whole bytes
  assign m_axis_tdata = {{(OUT_DATA_W - DATA_W - COUNT_W){1'b0}}, entry_count, element};

endmodule

`default_nettype wire

// ----- hdl/slt_ram.sv -----
// ----------------------------------------------------------------------------
// slt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/slt_dpath.sv -----
// ----------------------------------------------------------------------------
// slt_dpath
// Datapath: entry RAM, index and count registers, compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slt_dpath import slt_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic [DATA_W-1:0]   value_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [STATUS_W-1:0]      out_status_o,
  output logic [DATA_W-1:0]        out_element_o,
  output logic [COUNT_W-1:0]       out_count_o,
  output logic                     out_last_o
);

  logic [DATA_W-1:0]   value_q;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    raddr_full;
  logic [DATA_W-1:0]   rdata;
  logic [DATA_W-1:0]   wdata;
  logic [CNT_W:0]      idx_p1, idx_p2;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [DATA_W-1:0]   out_element_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_last_q;
  logic                out_free;

  // Latch the operand on input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      value_q <= value_i;
    end
  end

  // Index update
  always_comb begin
    case (cmd_i.idx_op)
      IDX_HOLD:  idx_d = idx_q;
      IDX_ZERO:  idx_d = '0;
      IDX_COUNT: idx_d = count_q;
      IDX_INC:   idx_d = idx_q + CNT_W'(1);
      IDX_DEC:   idx_d = idx_q - CNT_W'(1);
      default:   idx_d = idx_q;
    endcase
  end

  // Count update
  always_comb begin
    case (cmd_i.cnt_op)
      CNT_HOLD: count_d = count_q;
      CNT_INC:  count_d = count_q + CNT_W'(1);
      CNT_DEC:  count_d = count_q - CNT_W'(1);
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  // Select the read address
  always_comb begin
    case (cmd_i.rd_addr)
      RA_ZERO:   raddr_full = '0;
      RA_CNT_M1: raddr_full = count_q - CNT_W'(1);
      RA_IDX_M2: raddr_full = idx_q - CNT_W'(2);
      RA_IDX_P1: raddr_full = idx_q + CNT_W'(1);
      RA_IDX_P2: raddr_full = idx_q + CNT_W'(2);
      default:   raddr_full = '0;
    endcase
  end

  assign wdata = (cmd_i.wr_src == WS_VALUE) ? value_q : rdata;

  slt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (idx_q[ADDR_W-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr_full[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // Status toward the controller
  assign idx_p1 = {1'b0, idx_q} + (CNT_W+1)'(1);
  assign idx_p2 = {1'b0, idx_q} + (CNT_W+1)'(2);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.cnt_zero    = (count_q == '0);
    sts_o.cnt_full    = (count_q >= CNT_W'(CAPACITY));
    sts_o.rd_lt       = ($signed(rdata) < $signed(value_q));
    sts_o.rd_eq       = (rdata == value_q);
    sts_o.idx_is_one  = (idx_q == CNT_W'(1));
    sts_o.idx_p1_last = (idx_p1 == {1'b0, count_q});
    sts_o.idx_p2_end  = (idx_p2 >= {1'b0, count_q});
    sts_o.out_free    = out_free;
  end

  // Result register: hold until the downstream transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q  <= cmd_i.out_status;
      out_element_q <= cmd_i.out_elem ? rdata : '0;
      out_count_q   <= to_count_field(count_q);
      out_last_q    <= cmd_i.out_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_element_o = out_element_q;
  assign out_count_o   = out_count_q;
  assign out_last_o    = out_last_q;

  `ASSERT_IMPL(a_load_only_when_free, clk_i, rst_ni, cmd_i.out_load, out_free)
  `ASSERT_CLK(a_count_bounded, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY))
  `ASSERT_IMPL(a_no_grow_when_full, clk_i, rst_ni, cmd_i.cnt_op == CNT_INC,
               count_q < CNT_W'(CAPACITY))

endmodule

`default_nettype wire

// ----- hdl/slt_ctrl.sv -----
// ----------------------------------------------------------------------------
// slt_ctrl
// Controller: sequences insert, delete and dump over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slt_ctrl import slt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [OP_W-1:0] op_i,
  input  wire sts_t            sts_i,
  output cmd_t                 cmd_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;

  // Next state and pending response status
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(op_i))
            OP_INSERT: begin
              if (sts_i.cnt_full) begin
                state_d = S_RESP;
                st_d    = ST_FULL;
              end else if (sts_i.cnt_zero) begin
                state_d = S_INS_PLACE;
              end else begin
                state_d = S_INS_SHIFT;
              end
            end
            OP_DELETE: begin
              if (sts_i.cnt_zero) begin
                state_d = S_RESP;
                st_d    = ST_EMPTY;
              end else begin
                state_d = S_DEL_SCAN;
              end
            end
            OP_DUMP: begin
              if (sts_i.cnt_zero) begin
                state_d = S_RESP;
                st_d    = ST_EMPTY;
              end else begin
                state_d = S_DUMP;
              end
            end
            default: begin
              state_d = S_RESP;
              st_d    = ST_OK;
            end
          endcase
        end
      end
      S_INS_SHIFT: begin
        if (sts_i.rd_lt) begin
          state_d = S_RESP;
          st_d    = ST_OK;
        end else if (sts_i.idx_is_one) begin
          state_d = S_INS_PLACE;
        end
      end
      S_INS_PLACE: begin
        state_d = S_RESP;
        st_d    = ST_OK;
      end
      S_DEL_SCAN: begin
        if (sts_i.rd_eq) begin
          if (sts_i.idx_p1_last) begin
            state_d = S_RESP;
            st_d    = ST_OK;
          end else begin
            state_d = S_DEL_SHIFT;
          end
        end else if (sts_i.idx_p1_last) begin
          state_d = S_RESP;
          st_d    = ST_NOT_FOUND;
        end
      end
      S_DEL_SHIFT: begin
        if (sts_i.idx_p2_end) begin
          state_d = S_RESP;
          st_d    = ST_OK;
        end
      end
      S_DUMP: begin
        if (sts_i.out_free && sts_i.idx_p1_last) begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '{
      load_in:    1'b0,
      idx_op:     IDX_HOLD,
      rd_en:      1'b0,
      rd_addr:    RA_ZERO,
      wr_en:      1'b0,
      wr_src:     WS_RDATA,
      cnt_op:     CNT_HOLD,
      out_load:   1'b0,
      out_status: ST_OK,
      out_elem:   1'b0,
      out_last:   1'b1
    };
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          case (op_e'(op_i))
            OP_INSERT: begin
              if (sts_i.cnt_zero) begin
                cmd_o.idx_op = IDX_ZERO;
              end else begin
                cmd_o.idx_op  = IDX_COUNT;
                cmd_o.rd_en   = !sts_i.cnt_full;
                cmd_o.rd_addr = RA_CNT_M1;
              end
            end
            OP_DELETE, OP_DUMP: begin
              cmd_o.idx_op  = IDX_ZERO;
              cmd_o.rd_en   = !sts_i.cnt_zero;
              cmd_o.rd_addr = RA_ZERO;
            end
            default: cmd_o.idx_op = IDX_HOLD;
          endcase
        end
      end
      S_INS_SHIFT: begin
        // Move a larger or equal entry up, or drop the value into the gap
        cmd_o.wr_en = 1'b1;
        if (sts_i.rd_lt) begin
          cmd_o.wr_src = WS_VALUE;
          cmd_o.cnt_op = CNT_INC;
        end else begin
          cmd_o.wr_src  = WS_RDATA;
          cmd_o.idx_op  = IDX_DEC;
          cmd_o.rd_en   = !sts_i.idx_is_one;
          cmd_o.rd_addr = RA_IDX_M2;
        end
      end
      S_INS_PLACE: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WS_VALUE;
        cmd_o.cnt_op = CNT_INC;
      end
      S_DEL_SCAN: begin
        // Look ahead one entry while comparing the current one
        cmd_o.rd_en   = !sts_i.idx_p1_last;
        cmd_o.rd_addr = RA_IDX_P1;
        if (sts_i.rd_eq) begin
          if (sts_i.idx_p1_last) begin
            cmd_o.cnt_op = CNT_DEC;
          end
        end else if (!sts_i.idx_p1_last) begin
          cmd_o.idx_op = IDX_INC;
        end
      end
      S_DEL_SHIFT: begin
        // Pull the next entry down over the deleted slot
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WS_RDATA;
        if (sts_i.idx_p2_end) begin
          cmd_o.cnt_op = CNT_DEC;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = RA_IDX_P2;
          cmd_o.idx_op  = IDX_INC;
        end
      end
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_OK;
          cmd_o.out_elem   = 1'b1;
          cmd_o.out_last   = sts_i.idx_p1_last;
          if (!sts_i.idx_p1_last) begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = RA_IDX_P1;
            cmd_o.idx_op  = IDX_INC;
          end
        end
      end
      S_RESP: begin
        cmd_o.out_load   = sts_i.out_free;
        cmd_o.out_status = st_q;
      end
      default: cmd_o.out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  `ASSERT_IMPL(a_no_write_in_idle, clk_i, rst_ni, state_q == S_IDLE, !cmd_o.wr_en)
  `ASSERT_IMPL(a_no_shrink_when_empty, clk_i, rst_ni, cmd_o.cnt_op == CNT_DEC,
               !sts_i.cnt_zero)

endmodule

`default_nettype wire
